[sv/spq_pkg.sv]
package spq_pkg;

  localparam int unsigned PRIO_W = 4;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned OCC_W  = 8;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // broadcast to every cell for one accepted beat
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

  // handed from cell k to cell k+1
  typedef struct packed {
    logic   take;
    entry_t entry;
  } cell_link_t;

endpackage

[sv/spq_in_if.sv]
interface spq_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  prio_value;
  logic [15:0] packet_tag;

  modport source (output valid, output mode, output prio_value, output packet_tag,
                  input ready);
  modport sink   (input valid, input mode, input prio_value, input packet_tag,
                  output ready);
endinterface

[sv/spq_out_if.sv]
interface spq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_tag;
  logic [3:0]  out_prio;
  logic [7:0]  occupancy;

  modport source (output valid, output status, output out_tag, output out_prio,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_tag, input out_prio,
                  input occupancy, output ready);
endinterface

[sv/spq_cell.sv]
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_entry_i,
  input  logic       occ_i,
  input  cell_link_t prev_i,
  input  entry_t     next_entry_i,
  output cell_link_t link_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;
  logic   take;

  // queue is sorted, so take is set from the insertion point onward
  assign take = !occ_i || (entry_q.prio > new_entry_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (prev_i.take) begin
        entry_d = prev_i.entry;
      end else if (take) begin
        entry_d = new_entry_i;
      end
    end else if (ctrl_i.deq) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o.take  = take;
  assign link_o.entry = entry_q;
  assign entry_o      = entry_q;

endmodule

[sv/stable_priority_queue.sv]
// channel  | dir | modport | payload
// in_i     | in  | sink    | mode, prio_value, packet_tag
// out_o    | out | source  | status, out_tag, out_prio, occupancy
//
// one beat per cycle unless the output stalls: every enqueue or dequeue
// completes in the cycle it is accepted, the row of cells shifting right from
// the insertion point or left toward the head; the result is registered.
// after reset the queue is empty and no result is pending.
// a held result does not block the input if the sink takes it in the same cycle.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q;
  status_e       status_q, status_d;
  entry_t        res_q, res_d;
  logic [OCC_W-1:0] occ_q;

  logic       acc, full, empty;
  cell_ctrl_t ctrl;
  entry_t     new_entry;
  entry_t     entries [QUEUE_DEPTH];
  cell_link_t links   [QUEUE_DEPTH+1];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign full       = (count_q == CW'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);

  assign ctrl.enq = acc && (in_i.mode == MODE_ENQ) && !full;
  assign ctrl.deq = acc && (in_i.mode == MODE_DEQ) && !empty;

  assign new_entry.prio = in_i.prio_value;
  assign new_entry.tag  = in_i.packet_tag;

  assign links[0].take  = 1'b0;
  assign links[0].entry = new_entry;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    entry_t next_entry;
    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign next_entry = entries[k];
    end else begin : g_mid
      assign next_entry = entries[k+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_entry_i  (new_entry),
      .occ_i        (CW'(k) < count_q),
      .prev_i       (links[k]),
      .next_entry_i (next_entry),
      .link_o       (links[k+1]),
      .entry_o      (entries[k])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    res_d    = '0;
    if (ctrl.enq) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.deq) begin
      count_d = count_q - 1'b1;
      res_d   = entries[0];
    end else if (in_i.mode == MODE_ENQ) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= status_d;
      res_q    <= res_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.out_tag   = res_q.tag;
  assign out_o.out_prio  = res_q.prio;
  assign out_o.occupancy = occ_q;

endmodule
